[rtl/lph_pkg.sv]
// Package for the linear probing hash table: constants, types and hash helpers.
`timescale 1ns / 1ps
package lph_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned KEY_BYTES_DEF = 8;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_MUL   = 64'h00000100000001b3;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_UPDATE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_PROBE,
    S_DONE
  } state_t;

  // One hash step: fold in a byte, then multiply by the FNV prime. The prime is
  // 2^40 + 0x1b3, so the product is a shift plus a 9-bit constant multiply.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    begin
      x = h ^ {56'd0, b};
      return (x << 40) + (x * 64'h1b3);
    end
  endfunction

  function automatic logic [63:0] key_mask(input logic [3:0] len);
    logic [63:0] m;
    begin
      m = '0;
      for (int i = 0; i < 8; i++) begin
        if (i < int'(len)) m[8*i +: 8] = 8'hff;
      end
      return m;
    end
  endfunction

endpackage

[rtl/linear_probe_hash_table.sv]
// Top level of the linear probing hash table.
//
//   channel  dir  tdata (low bit up)                               tuser
//   s        in   command[1:0] key_bytes[65:2] key_len[69:66]
//                 value_in[133:70], zero padded to 136             -
//   m        out  status[2:0] value_out[66:3], zero padded to 72   -
//
// A transaction passes an accept state, a hash state that folds in each key byte,
// a memory read and a compare per probed slot, and a result state; a bad length or
// a full table skips the probe. The probe loop through the single-port entry memory
// dominates the time. After reset a clearing pass writes every entry, with s_tready low.
// A result waits in the output register; a new transaction is taken once it is gone.
`timescale 1ns / 1ps
module linear_probe_hash_table
  import lph_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // command, key_bytes, key_len, value_in
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata    // status, value_out
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned EW = 2 + 4 + 64 + 64;  // used, tomb, len, key, value
  localparam logic [AW:0] HALF = (AW + 1)'(CAPACITY / 2);

  state_t state, state_next;
  logic [1:0]    cmd;
  logic [63:0]   key, val, hash;
  logic [3:0]    len, byte_idx;
  logic [AW-1:0] pos, tomb_pos, clr_addr;
  logic          tomb_seen, clearing;
  logic [AW:0]   probes, live_count;
  logic [2:0]    status;
  logic [63:0]   vout;

  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;

  lph_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic          r_used, r_tomb, hit;
  logic [3:0]    r_len;
  logic [63:0]   r_key, r_val;
  assign {r_val, r_key, r_len, r_tomb, r_used} = rdata;
  assign hit = r_used && r_len == len && r_key == key;

  logic bad_len;
  assign bad_len = s_tdata[69:66] == 4'd0 || s_tdata[69:66] > 4'(KEY_BYTES);

  assign s_tready = state == S_IDLE && !clearing;
  assign m_tvalid = state == S_DONE;
  assign m_tdata  = {5'd0, vout, status};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid && s_tready) state_next = S_HASH;
      S_HASH:  if (status != ST_OK || byte_idx == len) state_next =
                   (status != ST_OK) ? S_DONE : S_READ;
      S_READ:  state_next = S_PROBE;
      S_PROBE: if (hit || (!r_used && !r_tomb) || probes == (AW + 1)'(CAPACITY - 1))
                 state_next = S_DONE;
               else state_next = S_READ;
      S_DONE:  if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port: clearing, probe reads, and the single write at the end of a probe.
  always_comb begin
    we    = 1'b0;
    addr  = pos;
    wdata = rdata;
    if (clearing) begin
      we = 1'b1;
      addr = clr_addr;
      wdata = '0;
    end else if (state == S_PROBE) begin
      if (hit && cmd == CMD_REMOVE) begin
        we = 1'b1;
        wdata = {r_val, r_key, r_len, 1'b1, 1'b0};
      end else if (hit && cmd == CMD_UPDATE) begin
        we = 1'b1;
        wdata = {val, r_key, r_len, r_tomb, r_used};
      end else if (!hit && cmd == CMD_INSERT && state_next == S_DONE &&
                   (tomb_seen || !r_used)) begin
        // The insert lands only once the probe has ended without a live match.
        we = 1'b1;
        addr = tomb_seen ? tomb_pos : pos;
        wdata = {val, key, len, 2'b01};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clearing <= 1'b1;
      clr_addr <= '0;
      live_count <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(CAPACITY - 1)) clearing <= 1'b0;
      end
      if (state == S_PROBE && we) begin
        if (cmd == CMD_INSERT) live_count <= live_count + 1'b1;
        else if (cmd == CMD_REMOVE && live_count != '0) live_count <= live_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd <= s_tdata[1:0];
        len <= s_tdata[69:66];
        key <= s_tdata[65:2] & key_mask(s_tdata[69:66]);
        val <= s_tdata[133:70];
        hash <= FNV_BASIS;
        byte_idx <= '0;
        vout <= '0;
        tomb_seen <= 1'b0;
        probes <= '0;
        if (bad_len) status <= ST_BAD_LEN;
        else if (s_tdata[1:0] == CMD_INSERT && live_count + 1'b1 >= HALF) status <= ST_FULL;
        else status <= ST_OK;
      end
      S_HASH: begin
        if (byte_idx != len) begin
          hash <= fnv_step(hash, key[{byte_idx[2:0], 3'b000} +: 8]);
          byte_idx <= byte_idx + 1'b1;
        end else pos <= hash[AW-1:0];
      end
      S_READ: ;
      S_PROBE: begin
        probes <= probes + 1'b1;
        pos <= pos + 1'b1;
        if (!r_used && r_tomb && !tomb_seen) begin
          tomb_seen <= 1'b1;
          tomb_pos <= pos;
        end
        if (hit) begin
          if (cmd == CMD_INSERT) status <= ST_DUPLICATE;
          else if (cmd == CMD_LOOKUP) vout <= r_val;
        end else if (state_next == S_DONE) begin
          if (cmd != CMD_INSERT) status <= ST_NOT_FOUND;
          else if (!we) status <= ST_FULL;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("input taken during clearing pass");
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count < HALF) else $error("live count beyond half capacity");
  a_vout_lookup: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[66:3] != 64'd0 |-> cmd == CMD_LOOKUP && m_tdata[2:0] == ST_OK)
    else $error("value returned by non-lookup");

endmodule

[rtl/lph_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule
